/* design/orsm_pkg.sv */
package orsm_pkg;

  // Field widths
  localparam int unsigned TimeW  = 32;
  localparam int unsigned RangeW = 16;

  // Stream packing widths (padded to whole bytes)
  localparam int unsigned InDataW  = 72;
  localparam int unsigned InUserW  = 8;
  localparam int unsigned OutDataW = 40;

  // Configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] RegMaxDepth    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMinAltitude = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMaxMission  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegEntryDwell  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegExitDwell   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegReqEntry    = 3'd5;

  localparam logic [TimeW-1:0] EntryDwellRst = 32'd1000;
  localparam logic [TimeW-1:0] ExitDwellRst  = 32'd500;
  localparam logic [TimeW-1:0] TimeMax       = '1;

  typedef struct packed {
    logic [RangeW-1:0] max_depth_cm;
    logic [RangeW-1:0] min_altitude_cm;
    logic [TimeW-1:0]  max_mission_ms;
    logic [TimeW-1:0]  entry_dwell_ms;
    logic [TimeW-1:0]  exit_dwell_ms;
    logic              require_entry;
  } cfg_t;

  typedef struct packed {
    logic [TimeW-1:0]  now_ms;
    logic              position_valid;
    logic              inside_region;
    logic              depth_valid;
    logic [RangeW-1:0] depth_cm;
    logic              altitude_valid;
    logic [RangeW-1:0] altitude_cm;
  } item_t;

  typedef struct packed {
    logic             first_update;
    logic [TimeW-1:0] start_ms;
    logic [TimeW-1:0] last_ms;
    logic             was_inside;
    logic [TimeW-1:0] inside_dwell_ms;
    logic [TimeW-1:0] outside_dwell_ms;
    logic             entry_flag;
  } state_t;

  typedef struct packed {
    logic             region_fault;
    logic             position_missing;
    logic             depth_fault;
    logic             altitude_fault;
    logic             timeout_fault;
    logic             entry_ok;
    logic [TimeW-1:0] time_remaining_ms;
  } result_t;

  // Saturating 32-bit add
  function automatic logic [TimeW-1:0] sat_add(input logic [TimeW-1:0] a,
                                               input logic [TimeW-1:0] b);
    logic [TimeW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TimeW] ? TimeMax : s[TimeW-1:0];
  endfunction

  // a - b, floored at zero
  function automatic logic [TimeW-1:0] diff_floor(input logic [TimeW-1:0] a,
                                                  input logic [TimeW-1:0] b);
    return (a >= b) ? (a - b) : '0;
  endfunction

endpackage

/* design/orsm_eval.sv */
module orsm_eval (
  input  orsm_pkg::cfg_t    cfg_i,
  input  orsm_pkg::item_t   item_i,
  input  orsm_pkg::state_t  state_i,
  output orsm_pkg::state_t  state_o,
  output orsm_pkg::result_t result_o
);
  import orsm_pkg::*;

  logic [TimeW-1:0] start_eff;
  logic [TimeW-1:0] delta;
  logic [TimeW-1:0] elapsed;

  // Time step and elapsed time; the first update starts the mission clock
  always_comb begin
    start_eff = state_i.first_update ? item_i.now_ms : state_i.start_ms;
    delta     = state_i.first_update ? '0 : diff_floor(item_i.now_ms, state_i.last_ms);
    elapsed   = diff_floor(item_i.now_ms, start_eff);
  end

  // Region dwell tracking and fault evaluation
  always_comb begin
    state_o              = state_i;
    state_o.first_update = 1'b0;
    state_o.start_ms     = start_eff;
    state_o.last_ms      = item_i.now_ms;

    result_o             = '0;

    if (!item_i.position_valid) begin
      result_o.position_missing = 1'b1;
    end else if (item_i.inside_region) begin
      state_o.outside_dwell_ms = '0;
      state_o.inside_dwell_ms  = state_i.was_inside ?
                                 sat_add(state_i.inside_dwell_ms, delta) : '0;
      state_o.was_inside       = 1'b1;
      if (state_o.inside_dwell_ms >= cfg_i.entry_dwell_ms) begin
        state_o.entry_flag = 1'b1;
      end
    end else begin
      state_o.inside_dwell_ms  = '0;
      state_o.outside_dwell_ms = state_i.was_inside ?
                                 '0 : sat_add(state_i.outside_dwell_ms, delta);
      state_o.was_inside       = 1'b0;
      result_o.region_fault    = (state_o.outside_dwell_ms >= cfg_i.exit_dwell_ms) &&
                                 (!cfg_i.require_entry || state_i.entry_flag);
    end

    // Depth and altitude limits; a zero limit disables the check
    if (cfg_i.max_depth_cm != '0) begin
      result_o.depth_fault = !item_i.depth_valid ||
                             (item_i.depth_cm > cfg_i.max_depth_cm);
    end
    if (cfg_i.min_altitude_cm != '0) begin
      result_o.altitude_fault = !item_i.altitude_valid ||
                                (item_i.altitude_cm < cfg_i.min_altitude_cm);
    end

    // Mission timeout
    if (cfg_i.max_mission_ms != '0) begin
      result_o.timeout_fault     = elapsed > cfg_i.max_mission_ms;
      result_o.time_remaining_ms = diff_floor(cfg_i.max_mission_ms, elapsed);
    end

    result_o.entry_ok = state_o.entry_flag;
  end

endmodule

/* design/operating_region_safety_monitor_unit.sv */
// Operating-region safety monitor.
// Input stream (s_axis_*): one navigation update per item; timestamp, region
// bit and depth/altitude readings in tdata, the three reading-valid flags in
// tuser. Output stream (m_axis_*): one result item per update with the region,
// position-missing, depth, altitude and timeout flags, the entry flag and the
// mission time remaining.
// Configuration (cfg_*): index plus 32-bit data, always ready; write it only
// while no item is in flight. Indexes past the register list are ignored.
// A result passes through the input register, then the result register,
// before it is valid on m_axis. Throughput: one item per cycle while
// m_axis_tready is high, limited by the single evaluation stage that
// updates the dwell state.
// When m_axis_tready is low the result register holds, the input register
// fills, and s_axis_tready drops; nothing is lost and no bubble is added.
// Reset clears the valid flags, restores the register defaults and returns the
// monitor to its first-update state with all dwell times at zero.
module operating_region_safety_monitor_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // config write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [orsm_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [orsm_pkg::CfgDataW-1:0]    cfg_data_i,
  // input item stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [31:0] now_ms, [32] inside_region, [48:33] depth_cm, [64:49] altitude_cm
  input  logic [orsm_pkg::InDataW-1:0]     s_axis_tdata,
  // [0] position_valid, [1] depth_valid, [2] altitude_valid
  input  logic [orsm_pkg::InUserW-1:0]     s_axis_tuser,
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [0] region_fault, [1] position_missing, [2] depth_fault, [3] altitude_fault,
  // [4] timeout_fault, [5] entry flag, [37:6] time_remaining_ms
  output logic [orsm_pkg::OutDataW-1:0]    m_axis_tdata
);
  import orsm_pkg::*;

  cfg_t    cfg_q;
  item_t   item_q;
  logic    in_valid_q;
  state_t  state_q, state_d;
  result_t res_q, res_d;
  logic    out_valid_q;
  logic    advance;
  item_t   item_in;

  // Unpack the incoming item
  always_comb begin
    item_in.now_ms         = s_axis_tdata[31:0];
    item_in.inside_region  = s_axis_tdata[32];
    item_in.depth_cm       = s_axis_tdata[48:33];
    item_in.altitude_cm    = s_axis_tdata[64:49];
    item_in.position_valid = s_axis_tuser[0];
    item_in.depth_valid    = s_axis_tuser[1];
    item_in.altitude_valid = s_axis_tuser[2];
  end

  // Pipeline handshake
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_depth_cm    <= '0;
      cfg_q.min_altitude_cm <= '0;
      cfg_q.max_mission_ms  <= '0;
      cfg_q.entry_dwell_ms  <= EntryDwellRst;
      cfg_q.exit_dwell_ms   <= ExitDwellRst;
      cfg_q.require_entry   <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegMaxDepth:    cfg_q.max_depth_cm    <= cfg_data_i[RangeW-1:0];
        RegMinAltitude: cfg_q.min_altitude_cm <= cfg_data_i[RangeW-1:0];
        RegMaxMission:  cfg_q.max_mission_ms  <= cfg_data_i[TimeW-1:0];
        RegEntryDwell:  cfg_q.entry_dwell_ms  <= cfg_data_i[TimeW-1:0];
        RegExitDwell:   cfg_q.exit_dwell_ms   <= cfg_data_i[TimeW-1:0];
        RegReqEntry:    cfg_q.require_entry   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q <= item_in;
    end
  end

  // Evaluation stage
  orsm_eval u_eval (
    .cfg_i    (cfg_q),
    .item_i   (item_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // Monitor state, updated once per evaluated item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.first_update     <= 1'b1;
      state_q.start_ms         <= '0;
      state_q.last_ms          <= '0;
      state_q.was_inside       <= 1'b0;
      state_q.inside_dwell_ms  <= '0;
      state_q.outside_dwell_ms <= '0;
      state_q.entry_flag       <= 1'b0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, res_q.time_remaining_ms, res_q.entry_ok,
                          res_q.timeout_fault, res_q.altitude_fault,
                          res_q.depth_fault, res_q.position_missing,
                          res_q.region_fault};

endmodule
